// ===== sv/circular_queue_with_search_defines.svh =====
// ----------------------------------------------------------------------------
// Circular queue with search: assertion macros
// Shared helpers for concurrent checks clocked by aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_SEARCH_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define CQS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that must hold in the same cycle whenever the trigger holds.
`define CQS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/cqs_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular queue with search: package
// Sizes, command and status codes, beat types and controller interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package cqs_pkg;

    // Number of storage slots in the ring (2 to 127).
    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int POS_W = 7;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_DISPLAY = 2'd2,
        CMD_SEARCH  = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        STS_INSERTED  = 3'd0,
        STS_OVERFLOW  = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_UNDERFLOW = 3'd3,
        STS_LISTED    = 3'd4,
        STS_EMPTY     = 3'd5,
        STS_MATCH     = 3'd6,
        STS_NOMATCH   = 3'd7
    } status_t;

    typedef struct packed {
        command_t                  command;
        logic signed [WORD_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  data;
        logic [POS_W-1:0]          position;
        logic                      last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // an input beat is taken this cycle
        logic step;     // the scanned entry is consumed this cycle
        logic finish;   // the closing result is written this cycle
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // the output register can take a result
        logic insert_cmd;   // the offered beat is an insert
        logic no_entries;   // the offered beat walks no entries
        logic step_ok;      // the scanned entry can be consumed
        logic scan_last;    // the scanned entry is the final one
    } dp_sts_t;

    // Advance a slot index around the ring.
    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== sv/cqs_ram.sv =====
// ----------------------------------------------------------------------------
// Circular queue with search: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/cqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Circular queue with search: controller
// Sequences acceptance, the slot walk and the closing result of each command.
// ----------------------------------------------------------------------------
`default_nettype none

module cqs_ctrl
    import cqs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Handshake and datapath commands.
    always_comb begin
        s_ready    = (state_reg == S_IDLE) && sts.out_free;
        cmd.accept = s_valid && s_ready;
        cmd.step   = (state_reg == S_SCAN) && sts.step_ok;
        cmd.finish = (state_reg == S_FINISH) && sts.out_free;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && !sts.insert_cmd) begin
                    state_next = sts.no_entries ? S_FINISH : S_READ;
                end
            end
            S_READ: begin
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (cmd.step && sts.scan_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (cmd.finish) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cqs_dp.sv =====
// ----------------------------------------------------------------------------
// Circular queue with search: datapath
// Ring pointers, slot RAM, walk counters, pending result and output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_queue_with_search_defines.svh"

module cqs_dp
    import cqs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire in_item_t s_data,
    output out_item_t     m_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire dp_cmd_t  cmd,
    output dp_sts_t       sts
);

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    command_t          op_reg, op_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic              pend_valid_reg, pend_valid_next;
    out_item_t         pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_data_reg, m_data_next;

    logic              full;
    logic              empty;
    logic              out_free;
    logic              out_load;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              qualifies;
    status_t           entry_status;
    status_t           none_status;

    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign empty    = (fill_reg == '0);
    assign out_free = !m_valid_reg || m_ready;

    // Status toward the controller.
    always_comb begin
        sts.out_free   = out_free;
        sts.insert_cmd = (s_data.command == CMD_INSERT);
        sts.no_entries = empty;
        sts.step_ok    = !qualifies || !pend_valid_reg || out_free;
        sts.scan_last  = (rem_reg == CNT_W'(1));
    end

    // Slot storage: inserts write at the tail, the walk reads one slot a cycle unless a stall holds it.
    assign ram_we    = cmd.accept && (s_data.command == CMD_INSERT) && !full;
    assign ram_raddr = (cmd.step && !sts.scan_last) ? next_index(idx_reg) : idx_reg;

    cqs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (s_data.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Classify the entry under scan and the result when nothing was reported.
    always_comb begin
        qualifies    = (op_reg != CMD_SEARCH) || (ram_rdata == key_reg);
        entry_status = STS_MATCH;
        none_status  = STS_NOMATCH;
        case (op_reg)
            CMD_DELETE: begin
                entry_status = STS_REMOVED;
                none_status  = STS_UNDERFLOW;
            end
            CMD_DISPLAY: begin
                entry_status = STS_LISTED;
                none_status  = STS_EMPTY;
            end
            default: begin
                entry_status = STS_MATCH;
                none_status  = STS_NOMATCH;
            end
        endcase
    end

    // Pointer, walk and pending-result updates.
    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        if (cmd.accept) begin
            op_next         = s_data.command;
            key_next        = s_data.value;
            idx_next        = head_reg;
            pend_valid_next = 1'b0;
            rem_next        = fill_reg;
            case (s_data.command)
                CMD_INSERT: begin
                    if (!full) begin
                        tail_next = next_index(tail_reg);
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                CMD_DELETE: begin
                    rem_next = empty ? '0 : CNT_W'(1);
                    if (!empty) begin
                        head_next = next_index(head_reg);
                        fill_next = fill_reg - CNT_W'(1);
                    end
                end
                default: begin
                    rem_next = fill_reg;
                end
            endcase
        end

        if (cmd.step) begin
            idx_next = next_index(idx_reg);
            rem_next = rem_reg - CNT_W'(1);
            if (qualifies) begin
                pend_valid_next    = 1'b1;
                pend_next.status   = entry_status;
                pend_next.data     = ram_rdata;
                pend_next.position = POS_W'(idx_reg) + POS_W'(1);
                pend_next.last     = 1'b0;
            end
        end
    end

    // Output register: a result is held until the beat is taken.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        out_load     = 1'b0;

        if (cmd.accept && (s_data.command == CMD_INSERT)) begin
            out_load             = 1'b1;
            m_data_next.status   = full ? STS_OVERFLOW : STS_INSERTED;
            m_data_next.data     = '0;
            m_data_next.position = full ? '0 : POS_W'(tail_reg) + POS_W'(1);
            m_data_next.last     = 1'b1;
        end else if (cmd.step && qualifies && pend_valid_reg) begin
            out_load    = 1'b1;
            m_data_next = pend_reg;
        end else if (cmd.finish) begin
            out_load = 1'b1;
            if (pend_valid_reg) begin
                m_data_next      = pend_reg;
                m_data_next.last = 1'b1;
            end else begin
                m_data_next.status   = none_status;
                m_data_next.data     = '0;
                m_data_next.position = '0;
                m_data_next.last     = 1'b1;
            end
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            idx_reg        <= '0;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            idx_reg        <= idx_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The fill count never passes the ring size.
    `CQS_ASSERT_ALWAYS(a_fill_range, fill_reg <= CNT_W'(DEPTH), "fill count beyond depth")
    // An empty or full ring has its pointers on the same slot.
    `CQS_ASSERT_IMPLIES(a_ring_ptrs, empty || full, head_reg == tail_reg, "ring pointers disagree")
    // A new result never overwrites one that is still waiting.
    `CQS_ASSERT_IMPLIES(a_no_overwrite, out_load, out_free, "result overwritten")
    // The walk never steps past its last entry.
    `CQS_ASSERT_IMPLIES(a_walk_count, cmd.step, rem_reg != '0, "walk ran past its entries")

endmodule

`default_nettype wire

// ===== sv/circular_queue_with_search.sv =====
// ----------------------------------------------------------------------------
// Circular queue with search: top level
// Bounded ring of signed words with insert, delete, display and key search.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH (package constant) signed 32-bit words. Each input
// beat carries a command and a value; each result beat carries a status, a word,
// the 1-based slot of that word and a last flag on the final result of a command.
// One command is handled at a time. An insert is answered straight from the idle
// state; a delete, display or search reads the held words through the single read
// port of the slot RAM, which has registered read data and walks one slot per cycle
// unless a stalled result holds it. On an empty queue they walk no slots. Each result sits
// in an output register, so a stalled result beat holds the walk but is never lost.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_queue_with_search
    import cqs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data
);

    dp_cmd_t dp_cmd;
    dp_sts_t dp_sts;

    // Command sequencing.
    cqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    // Storage, pointers and result formation.
    cqs_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (dp_cmd),
        .sts     (dp_sts)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the circular queue with search
// Drives insert, delete, display and search beats in random bursts, keeps its
// own ring-buffer predictor, and checks every result beat against it while the
// result channel stalls on a changing pattern.
// ----------------------------------------------------------------------------

module tb_top;
    import cqs_pkg::*;

    // One pending input beat; a set hold flag keeps it back until all results are in.
    typedef struct packed {
        logic     hold;
        in_item_t beat;
    } pending_beat_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    pending_beat_t command_backlog[$];
    out_item_t     expected_results[$];
    int            mismatch_count = 0;

    // Predictor state: a ring of words with oldest slot, next free slot and count.
    logic signed [WORD_W-1:0] ring_words [DEPTH];
    int ring_head = 0;
    int ring_tail = 0;
    int ring_fill = 0;

    // Sender burst control and receiver stall pattern.
    int          burst_left = 1;
    int          gap_left = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age = 0;

    // Words the stimulus expects to be held, used to aim search keys at real entries.
    logic signed [WORD_W-1:0] held_words[$];

    circular_queue_with_search dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Work out the result beats that one accepted command produces.
    function automatic void predict_queue_command(input in_item_t beat);
        out_item_t batch[$];
        out_item_t res;
        int idx;
        int k;
        res = '0;
        case (beat.command)
            CMD_INSERT: begin
                if (ring_fill == DEPTH) begin
                    res.status = STS_OVERFLOW;
                    batch.push_back(res);
                end else begin
                    ring_words[ring_tail] = beat.value;
                    res.status = STS_INSERTED;
                    res.position = POS_W'(ring_tail + 1);
                    batch.push_back(res);
                    ring_tail = (ring_tail + 1) % DEPTH;
                    ring_fill++;
                end
            end
            CMD_DELETE: begin
                if (ring_fill == 0) begin
                    res.status = STS_UNDERFLOW;
                    batch.push_back(res);
                end else begin
                    res.status = STS_REMOVED;
                    res.data = ring_words[ring_head];
                    res.position = POS_W'(ring_head + 1);
                    batch.push_back(res);
                    ring_head = (ring_head + 1) % DEPTH;
                    ring_fill--;
                end
            end
            CMD_DISPLAY: begin
                if (ring_fill == 0) begin
                    res.status = STS_EMPTY;
                    batch.push_back(res);
                end else begin
                    idx = ring_head;
                    for (k = 0; k < ring_fill; k++) begin
                        res.status = STS_LISTED;
                        res.data = ring_words[idx];
                        res.position = POS_W'(idx + 1);
                        batch.push_back(res);
                        idx = (idx + 1) % DEPTH;
                    end
                end
            end
            default: begin
                // The walk covers every held entry in queue order, across the wrap.
                idx = ring_head;
                for (k = 0; k < ring_fill; k++) begin
                    if (ring_words[idx] == beat.value) begin
                        res.status = STS_MATCH;
                        res.data = ring_words[idx];
                        res.position = POS_W'(idx + 1);
                        batch.push_back(res);
                    end
                    idx = (idx + 1) % DEPTH;
                end
                if (batch.size() == 0) begin
                    res = '0;
                    res.status = STS_NOMATCH;
                    batch.push_back(res);
                end
            end
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) expected_results.push_back(batch[i]);
    endfunction

    // Queue one command for the driver and follow its effect on the held words.
    task automatic add_command(input command_t cmd, input logic signed [WORD_W-1:0] value,
                               input logic hold);
        pending_beat_t pb;
        pb.hold = hold;
        pb.beat.command = cmd;
        pb.beat.value = value;
        command_backlog.push_back(pb);
        if (cmd == CMD_INSERT && held_words.size() < DEPTH) held_words.push_back(value);
        if (cmd == CMD_DELETE && held_words.size() > 0) void'(held_words.pop_front());
    endtask

    // Words drawn mostly from a small pool so that searches find duplicates.
    function automatic logic signed [WORD_W-1:0] pick_word();
        logic signed [WORD_W-1:0] w;
        case ($urandom_range(0, 5))
            0, 1: w = $urandom;
            2: w = 32'sh8000_0000;
            3: w = 32'sh7FFF_FFFF;
            4: w = -32'sd1;
            default: w = $urandom_range(0, 4);
        endcase
        return w;
    endfunction

    // Driver: offers the next pending beat in bursts separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_queue_command(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (command_backlog.size() > 0 &&
                             !(command_backlog[0].hold && expected_results.size() > 0)) begin
                    s_valid <= 1'b1;
                    s_data <= command_backlog[0].beat;
                    void'(command_backlog.pop_front());
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stalls the result channel and checks each accepted result beat.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat status %0d data %0d position %0d",
                         $time, m_data.status, m_data.data, m_data.position);
                mismatch_count++;
            end else begin
                if (m_data.status !== expected_results[0].status) begin
                    $display("%0t: status expected %0d got %0d", $time,
                             expected_results[0].status, m_data.status);
                    mismatch_count++;
                end
                if (m_data.data !== expected_results[0].data) begin
                    $display("%0t: data expected %0d got %0d", $time,
                             expected_results[0].data, m_data.data);
                    mismatch_count++;
                end
                if (m_data.position !== expected_results[0].position) begin
                    $display("%0t: position expected %0d got %0d", $time,
                             expected_results[0].position, m_data.position);
                    mismatch_count++;
                end
                if (m_data.last !== expected_results[0].last) begin
                    $display("%0t: last expected %0d got %0d", $time,
                             expected_results[0].last, m_data.last);
                    mismatch_count++;
                end
                void'(expected_results.pop_front());
            end
        end
        // A fresh stall pattern when the current one has aged out, sometimes with no stalls at all.
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pattern = 16'hFFFF;
                1: stall_pattern = 16'($urandom);
                2: stall_pattern = 16'($urandom & $urandom);
                default: stall_pattern = 16'hF0F0;
            endcase
            stall_pattern[0] = 1'b1;
            pattern_age = $urandom_range(16, 64);
        end
        pattern_age--;
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        m_ready <= aresetn && stall_pattern[0];
    end

    // Stimulus, reset and end of run.
    initial begin
        int n;
        int r;
        logic fill_phase;

        // Empty queue: every read-type command has nothing to walk.
        add_command(CMD_DISPLAY, $urandom, 1'b0);
        add_command(CMD_DELETE, $urandom, 1'b0);
        add_command(CMD_SEARCH, 32'sh7FFF_FFFF, 1'b0);
        // Fill to the brim with extreme words and a duplicate, then overflow.
        add_command(CMD_INSERT, 32'sh8000_0000, 1'b0);
        add_command(CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
        add_command(CMD_INSERT, 32'sh0000_0000, 1'b0);
        add_command(CMD_INSERT, -32'sd1, 1'b0);
        add_command(CMD_INSERT, 32'sh5555_5555, 1'b0);
        add_command(CMD_INSERT, 32'shAAAA_AAAA, 1'b0);
        add_command(CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
        add_command(CMD_INSERT, 32'sd1, 1'b0);
        add_command(CMD_INSERT, 32'sd2, 1'b0);
        add_command(CMD_DISPLAY, $urandom, 1'b1);
        add_command(CMD_SEARCH, 32'sh7FFF_FFFF, 1'b0);
        add_command(CMD_SEARCH, 32'sh1234_5678, 1'b0);
        // Free three slots and refill them so the ring wraps.
        add_command(CMD_DELETE, $urandom, 1'b0);
        add_command(CMD_DELETE, $urandom, 1'b0);
        add_command(CMD_DELETE, $urandom, 1'b0);
        add_command(CMD_INSERT, 32'sh5555_5555, 1'b0);
        add_command(CMD_INSERT, 32'sh8000_0000, 1'b0);
        add_command(CMD_INSERT, -32'sd1, 1'b0);
        add_command(CMD_SEARCH, 32'sh5555_5555, 1'b0);
        add_command(CMD_SEARCH, -32'sd1, 1'b0);
        add_command(CMD_DISPLAY, $urandom, 1'b0);

        // Random traffic that drifts between filling and draining the queue.
        fill_phase = 1'b0;
        for (n = 0; n < 147; n++) begin
            if (n % 24 == 0) fill_phase = ~fill_phase;
            r = $urandom_range(0, 99);
            if (r < (fill_phase ? 45 : 15)) begin
                add_command(CMD_INSERT, pick_word(), $urandom_range(0, 19) == 0);
            end else if (r < 60) begin
                add_command(CMD_DELETE, $urandom, $urandom_range(0, 19) == 0);
            end else if (r < 75) begin
                add_command(CMD_DISPLAY, $urandom, $urandom_range(0, 19) == 0);
            end else if (held_words.size() > 0 && $urandom_range(0, 2) != 0) begin
                add_command(CMD_SEARCH, held_words[$urandom_range(0, held_words.size() - 1)],
                            $urandom_range(0, 19) == 0);
            end else begin
                add_command(CMD_SEARCH, pick_word(), $urandom_range(0, 19) == 0);
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (command_backlog.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (24) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake or results that never arrive.
    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule
